// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge once reset is released.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lmbs_pkg.sv -----
// Shared types, constants and codes of the LED matrix scanner.
package lmbs_pkg;

  localparam int PANEL_COLUMNS_DEF = 32;
  localparam int PANEL_ROWS_DEF    = 32;
  localparam int ROW_GROUPS_DEF    = 16;
  localparam int PLANE_COUNT_DEF   = 4;

  localparam int LEVEL_W    = 8;
  localparam int COLUMN_W   = 6;
  localparam int ROW_ADDR_W = 4;
  localparam int BASE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_ENABLE = 2'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic clr_wr;      // write zero at the clear address, advance it
    logic pix_wr;      // pixel write beat accepted
    logic restart;     // tick while scanning is off
    logic hold_tick;   // tick with no load pending
    logic load_start;  // tick that starts a load
    logic issue;       // read one column of the current row group
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic refresh_en;
    logic load_pending;
    logic issue_ok;
    logic col_last;
  } dp_status_t;

  typedef struct packed {
    logic [COLUMN_W-1:0]   column;
    logic                  red_upper;
    logic                  green_upper;
    logic                  blue_upper;
    logic                  red_lower;
    logic                  green_lower;
    logic                  blue_lower;
    logic [ROW_ADDR_W-1:0] row;
    logic                  last;
  } out_item_t;

endpackage

// ----- hw/rtl/led_matrix_bcm_scanner.sv -----
// Top level of the binary code modulation LED matrix scanner.
//
//   channel | handshake           | content
//   --------+---------------------+------------------------------------------
//   in_     | in_valid / in_stall | pixel write or scan tick
//   out_    | out_valid/out_stall | one column beat of a row group load
//   cfg_    | cfg_valid/cfg_ready | register index and write data
//
// After reset the frame store is cleared one entry per cycle, all 2**(row bits +
// column bits) entries (1024 at the default size); input stays stalled meanwhile.
// A pixel write or a hold tick leaves the input open. A load tick stalls the input
// while the frame store reads the upper and lower row of one column per cycle
// through its two read ports into a two-entry result buffer.
// Output stalls pause the column reads; the input waits until all are issued.
module led_matrix_bcm_scanner #(
  parameter int PANEL_COLUMNS = lmbs_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = lmbs_pkg::PANEL_ROWS_DEF,
  parameter int ROW_GROUPS    = lmbs_pkg::ROW_GROUPS_DEF,
  parameter int PLANE_COUNT   = lmbs_pkg::PLANE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [lmbs_pkg::LEVEL_W-1:0]      in_pixel_x,
  input  logic [lmbs_pkg::LEVEL_W-1:0]      in_pixel_y,
  input  logic [lmbs_pkg::LEVEL_W-1:0]      in_red_level,
  input  logic [lmbs_pkg::LEVEL_W-1:0]      in_green_level,
  input  logic [lmbs_pkg::LEVEL_W-1:0]      in_blue_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lmbs_pkg::COLUMN_W-1:0]     out_column_index,
  output logic                              out_red_upper,
  output logic                              out_green_upper,
  output logic                              out_blue_upper,
  output logic                              out_red_lower,
  output logic                              out_green_lower,
  output logic                              out_blue_lower,
  output logic [lmbs_pkg::ROW_ADDR_W-1:0]   out_row_address,
  output logic                              out_latch_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lmbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lmbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  out_item_t  out_item;

  // Registers are plain flops, a write lands in any cycle.
  assign cfg_ready = 1'b1;

  lmbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  lmbs_datapath #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_ROWS    (PANEL_ROWS),
    .ROW_GROUPS    (ROW_GROUPS),
    .PLANE_COUNT   (PLANE_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_red_level   (in_red_level),
    .in_green_level (in_green_level),
    .in_blue_level  (in_blue_level),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

  assign out_column_index = out_item.column;
  assign out_red_upper    = out_item.red_upper;
  assign out_green_upper  = out_item.green_upper;
  assign out_blue_upper   = out_item.blue_upper;
  assign out_red_lower    = out_item.red_lower;
  assign out_green_lower  = out_item.green_lower;
  assign out_blue_lower   = out_item.blue_lower;
  assign out_row_address  = out_item.row;
  assign out_latch_last   = out_item.last;

endmodule

// ----- hw/rtl/lmbs_frame_mem.sv -----
// Frame store: one write port and two registered read ports.
module lmbs_frame_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/lmbs_datapath.sv -----
// Scanner datapath: config registers, scan counters, frame store and result buffer.
`include "assert_macros.svh"

module lmbs_datapath #(
  parameter int PANEL_COLUMNS = lmbs_pkg::PANEL_COLUMNS_DEF,
  parameter int PANEL_ROWS    = lmbs_pkg::PANEL_ROWS_DEF,
  parameter int ROW_GROUPS    = lmbs_pkg::ROW_GROUPS_DEF,
  parameter int PLANE_COUNT   = lmbs_pkg::PLANE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lmbs_pkg::ctrl_cmd_t              cmd,
  output lmbs_pkg::dp_status_t             sts,
  input  logic [lmbs_pkg::LEVEL_W-1:0]     in_pixel_x,
  input  logic [lmbs_pkg::LEVEL_W-1:0]     in_pixel_y,
  input  logic [lmbs_pkg::LEVEL_W-1:0]     in_red_level,
  input  logic [lmbs_pkg::LEVEL_W-1:0]     in_green_level,
  input  logic [lmbs_pkg::LEVEL_W-1:0]     in_blue_level,
  input  logic                             cfg_valid,
  input  logic [lmbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lmbs_pkg::out_item_t              out_item
);
  import lmbs_pkg::*;

  localparam int COL_W  = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
  localparam int ROW_W  = (PANEL_ROWS > 1) ? $clog2(PANEL_ROWS) : 1;
  localparam int RG_W   = (ROW_GROUPS > 1) ? $clog2(ROW_GROUPS) : 1;
  localparam int PL_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int HOLD_W = BASE_W + PLANE_COUNT - 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DATA_W = 3 * PLANE_COUNT;

  // Configuration registers.
  logic [BASE_W-1:0] base_ticks_r;
  logic              refresh_en_r;
  logic              cfg_disable;

  assign cfg_disable = cfg_valid && (cfg_index == CFG_REFRESH_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ticks_r <= BASE_W'(1);
      refresh_en_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_TICKS:     base_ticks_r <= cfg_data[BASE_W-1:0];
        CFG_REFRESH_ENABLE: refresh_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Scan state.
  logic [PL_W-1:0]   plane_r, plane_nxt;
  logic [RG_W-1:0]   row_grp_r, row_grp_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              load_pending_r, load_pending_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [BASE_W-1:0] base_eff;

  assign base_eff = (base_ticks_r == '0) ? BASE_W'(1) : base_ticks_r;

  always_comb begin
    plane_nxt        = plane_r;
    row_grp_nxt      = row_grp_r;
    hold_nxt         = hold_r;
    load_pending_nxt = load_pending_r;
    col_nxt          = col_r;
    if (cmd.restart || cfg_disable) begin
      plane_nxt        = '0;
      row_grp_nxt      = '0;
      hold_nxt         = '0;
      load_pending_nxt = 1'b1;
    end else if (cmd.load_start) begin
      hold_nxt         = HOLD_W'(base_eff) << plane_r;
      load_pending_nxt = 1'b0;
      col_nxt          = '0;
    end else if (cmd.hold_tick && (hold_r != '0)) begin
      hold_nxt = hold_r - HOLD_W'(1);
      if (hold_r == HOLD_W'(1)) begin
        // Hold expired: next row group, and on wrap the next plane.
        load_pending_nxt = 1'b1;
        if (row_grp_r == RG_W'(ROW_GROUPS - 1)) begin
          row_grp_nxt = '0;
          plane_nxt   = (plane_r == PL_W'(PLANE_COUNT - 1)) ? '0 : plane_r + PL_W'(1);
        end else begin
          row_grp_nxt = row_grp_r + RG_W'(1);
        end
      end
    end else if (cmd.issue) begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r        <= '0;
      row_grp_r      <= '0;
      hold_r         <= '0;
      load_pending_r <= 1'b1;
      col_r          <= '0;
    end else begin
      plane_r        <= plane_nxt;
      row_grp_r      <= row_grp_nxt;
      hold_r         <= hold_nxt;
      load_pending_r <= load_pending_nxt;
      col_r          <= col_nxt;
    end
  end

  // Clear pass address.
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // Frame store write side.
  logic              pix_in_range;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  assign pix_in_range = ({1'b0, in_pixel_x} < 9'(PANEL_COLUMNS))
                     && ({1'b0, in_pixel_y} < 9'(PANEL_ROWS));
  assign mem_we    = cmd.clr_wr || (cmd.pix_wr && pix_in_range);
  assign mem_waddr = cmd.clr_wr ? clr_addr_r
                                : {in_pixel_y[ROW_W-1:0], in_pixel_x[COL_W-1:0]};
  assign mem_wdata = cmd.clr_wr ? '0
                                : {in_blue_level[PLANE_COUNT-1:0],
                                   in_green_level[PLANE_COUNT-1:0],
                                   in_red_level[PLANE_COUNT-1:0]};

  // Frame store read side: upper and lower row of one column per beat.
  logic [5:0]        upper_row, lower_row;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;

  assign upper_row = 6'(row_grp_r);
  assign lower_row = upper_row + 6'(ROW_GROUPS);
  assign raddr_a   = {upper_row[ROW_W-1:0], col_r};
  assign raddr_b   = {lower_row[ROW_W-1:0], col_r};

  lmbs_frame_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Side information that travels with the read.
  logic                  rd_valid_r;
  logic [COLUMN_W-1:0]   rd_col_r;
  logic [ROW_ADDR_W-1:0] rd_row_r;
  logic                  rd_last_r;
  logic                  rd_up_ok_r;
  logic                  rd_lo_ok_r;
  logic [PL_W-1:0]       rd_plane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_col_r   <= COLUMN_W'(col_r);
      rd_row_r   <= ROW_ADDR_W'(row_grp_r);
      rd_last_r  <= sts.col_last;
      rd_up_ok_r <= upper_row < 6'(PANEL_ROWS);
      rd_lo_ok_r <= lower_row < 6'(PANEL_ROWS);
      rd_plane_r <= plane_r;
    end
  end

  // Pick the plane bit of each color out of the stored word.
  logic [PLANE_COUNT-1:0] up_r, up_g, up_b, lo_r, lo_g, lo_b;
  out_item_t              push_item;

  assign {up_b, up_g, up_r} = rdata_a;
  assign {lo_b, lo_g, lo_r} = rdata_b;

  always_comb begin
    push_item.column      = rd_col_r;
    push_item.red_upper   = rd_up_ok_r && up_r[rd_plane_r];
    push_item.green_upper = rd_up_ok_r && up_g[rd_plane_r];
    push_item.blue_upper  = rd_up_ok_r && up_b[rd_plane_r];
    push_item.red_lower   = rd_lo_ok_r && lo_r[rd_plane_r];
    push_item.green_lower = rd_lo_ok_r && lo_g[rd_plane_r];
    push_item.blue_lower  = rd_lo_ok_r && lo_b[rd_plane_r];
    push_item.row         = rd_row_r;
    push_item.last        = rd_last_r;
  end

  // Two-entry result buffer. A read is issued only when its beat has a slot.
  out_item_t  fifo_q [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fifo_cnt_r;
  logic       pop;
  logic [2:0] committed;

  assign pop       = out_valid && !out_stall;
  assign committed = 3'(fifo_cnt_r) + 3'(rd_valid_r) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      fifo_q[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= '0;
    end else begin
      if (rd_valid_r) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fifo_cnt_r <= 2'(3'(fifo_cnt_r) + 3'(rd_valid_r) - 3'(pop));
    end
  end

  assign out_valid = (fifo_cnt_r != '0);
  assign out_item  = fifo_q[rd_ptr_r];

  always_comb begin
    sts.clr_last     = (clr_addr_r == {ADDR_W{1'b1}});
    sts.refresh_en   = refresh_en_r;
    sts.load_pending = load_pending_r;
    sts.issue_ok     = (committed < 3'd2);
    sts.col_last     = (col_r == COL_W'(PANEL_COLUMNS - 1));
  end

  `ASSERT_CLK(a_buf_credit, (3'(fifo_cnt_r) + 3'(rd_valid_r)) <= 3'd2,
              "result buffer overrun: reads issued beyond free slots")
  `ASSERT_CLK(a_pending_hold, load_pending_r == (hold_r == '0),
              "load pending and hold counter disagree")
  `ASSERT_IMPL(a_last_col, out_valid && out_item.last,
               out_item.column == COLUMN_W'(PANEL_COLUMNS - 1),
               "latch beat not on the final column")

endmodule

// ----- hw/rtl/lmbs_ctrl.sv -----
// Scanner controller: clear pass, input acceptance and column shift sequencing.
`include "assert_macros.svh"

module lmbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_stall,
  output lmbs_pkg::ctrl_cmd_t  cmd,
  input  lmbs_pkg::dp_status_t sts
);
  import lmbs_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == KIND_PIXEL) begin
            cmd.pix_wr = 1'b1;
          end else if (!sts.refresh_en) begin
            cmd.restart = 1'b1;
          end else if (sts.load_pending) begin
            cmd.load_start = 1'b1;
            state_nxt      = ST_SHIFT;
          end else begin
            cmd.hold_tick = 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        cmd.issue = sts.issue_ok;
        if (sts.issue_ok && sts.col_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_issue_in_shift, cmd.issue, state_r == ST_SHIFT,
               "column read issued outside the shift phase")
  `ASSERT_IMPL(a_clear_stalls, state_r == ST_CLEAR, in_stall,
               "input open during the clear pass")
  `ASSERT_CLK(a_state_legal,
              (state_r == ST_CLEAR) || (state_r == ST_IDLE) || (state_r == ST_SHIFT),
              "controller in an undefined state")

endmodule
